// ===== sv/spcp_pkg.sv =====
// Shared widths, types and constants for the segment pair closest point pipeline.
// Used by every module of the block; depends on nothing.
package spcp_pkg;

    localparam int COORD_W    = 32;               // input coordinate, Q11.20
    localparam int NUM_COORDS = 12;
    localparam int IN_W       = COORD_W * NUM_COORDS;
    localparam int DIFF_W     = COORD_W + 1;      // endpoint differences
    localparam int PROD_W     = 2 * DIFF_W;       // one product of differences
    localparam int DOT_W      = PROD_W + 2;       // sum of three products
    localparam int HALF_W     = DOT_W / 2;        // split point of the wide multiplier
    localparam int WIDE_W     = 2 * DOT_W;        // determinant and numerators
    localparam int THR_W      = 16;
    localparam int PARAM_FRAC = 16;
    localparam int PARAM_W    = PARAM_FRAC + 1;
    localparam int DIV_STEPS  = PARAM_FRAC;
    localparam int TB_W       = PARAM_W + 1 + DIFF_W;     // parameter times difference
    localparam int EXACT_W    = TB_W + 1;
    localparam int SHIFT_W    = EXACT_W - PARAM_FRAC;
    localparam int GAP_W      = 33;
    localparam int SQ_W       = PROD_W + 2;       // running remainder of the root
    localparam int ROOT_W     = 33;
    localparam int OUT_BITS   = 2 * PARAM_W + 4 * GAP_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [PARAM_W-1:0] PARAM_ONE  = PARAM_W'(1) << PARAM_FRAC;
    localparam logic [PARAM_W-1:0] PARAM_HALF = PARAM_W'(1) << (PARAM_FRAC - 1);
    localparam logic signed [EXACT_W-1:0] ROUND_HALF = EXACT_W'(1) << (PARAM_FRAC - 1);
    localparam logic signed [GAP_W-1:0] GAP_MAX = {1'b0, {(GAP_W-1){1'b1}}};
    localparam logic signed [GAP_W-1:0] GAP_MIN = {1'b1, {(GAP_W-1){1'b0}}};

    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic [PARAM_W-1:0]        t_param;
    typedef logic signed [GAP_W-1:0]   t_gap;

    typedef struct packed {
        t_diff [2:0] a;     // end1 - start1
        t_diff [2:0] b;     // end2 - start2
        t_diff [2:0] c;     // start1 - start2
    } t_geom;

    typedef struct packed {
        t_geom geo;
        t_wide det;
        t_wide num_s;
        t_wide num_t;
    } t_div_in;

    typedef struct packed {
        t_geom  geo;
        t_param s;
        t_param t;
    } t_div_out;

    typedef struct packed {
        logic par;
        logic s_le0;
        logic s_ge1;
        logic t_le0;
        logic t_ge1;
    } t_div_flags;

    typedef struct packed {
        t_param     s;
        t_param     t;
        t_gap [2:0] g;
    } t_res;

endpackage

// ===== sv/segment_pair_closest_points.sv =====
// Closest points of two 3D segments: parameters s and t, gap vector and gap length.
// Accepts one item per cycle when the output is taken. A result held on the output
// stalls the whole pipeline in place.
// Reset (i_rst_n low at a clock edge) empties the pipeline and sets the threshold to 1.
// Depends on spcp_pkg, spcp_wmul, spcp_div and spcp_gap.
module segment_pair_closest_points import spcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // seg1_start_x/y/z, seg1_end_x/y/z, seg2_start_x/y/z, seg2_end_x/y/z, 32 bits each
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // param_first, param_second, gap_x, gap_y, gap_z, gap_length, zero pad
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // parallel_threshold
    input  logic [THR_W-1:0] i_cfg_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready
);

    logic             ce;
    logic [THR_W-1:0] r_thr;

    logic   r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    t_geom  n1_geo, r1_geo, r2_geo, r3_geo, r4_geo, r5_geo;
    logic signed [PROD_W-1:0] r2_aa [3], r2_bb [3], r2_ab [3], r2_ac [3], r2_bc [3];
    t_dot   r3_aa, r3_bb, r3_ab, r3_ac, r3_bc;
    t_wide  w_p [6];
    t_div_in  r6_div;
    logic     div_vld;
    t_div_out div_out;

    // advance everything unless a result is waiting and not taken
    assign ce              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_comb begin
        logic [COORD_W-1:0] p1, q1, p2, q2;
        for (int j = 0; j < 3; j++) begin
            p1 = i_s_axis_tdata[j*COORD_W +: COORD_W];
            q1 = i_s_axis_tdata[(3+j)*COORD_W +: COORD_W];
            p2 = i_s_axis_tdata[(6+j)*COORD_W +: COORD_W];
            q2 = i_s_axis_tdata[(9+j)*COORD_W +: COORD_W];
            n1_geo.a[j] = {q1[COORD_W-1], q1} - {p1[COORD_W-1], p1};
            n1_geo.b[j] = {q2[COORD_W-1], q2} - {p2[COORD_W-1], p2};
            n1_geo.c[j] = {p1[COORD_W-1], p1} - {p2[COORD_W-1], p2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (ce) begin
            r1_vld <= i_s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
        if (ce) begin
            r1_geo <= n1_geo;
            r2_geo <= r1_geo;
            r3_geo <= r2_geo;
            r4_geo <= r3_geo;
            r5_geo <= r4_geo;
            for (int j = 0; j < 3; j++) begin
                r2_aa[j] <= PROD_W'(r1_geo.a[j] * r1_geo.a[j]);
                r2_bb[j] <= PROD_W'(r1_geo.b[j] * r1_geo.b[j]);
                r2_ab[j] <= PROD_W'(r1_geo.a[j] * r1_geo.b[j]);
                r2_ac[j] <= PROD_W'(r1_geo.a[j] * r1_geo.c[j]);
                r2_bc[j] <= PROD_W'(r1_geo.b[j] * r1_geo.c[j]);
            end
            r3_aa <= DOT_W'(r2_aa[0]) + DOT_W'(r2_aa[1]) + DOT_W'(r2_aa[2]);
            r3_bb <= DOT_W'(r2_bb[0]) + DOT_W'(r2_bb[1]) + DOT_W'(r2_bb[2]);
            r3_ab <= DOT_W'(r2_ab[0]) + DOT_W'(r2_ab[1]) + DOT_W'(r2_ab[2]);
            r3_ac <= DOT_W'(r2_ac[0]) + DOT_W'(r2_ac[1]) + DOT_W'(r2_ac[2]);
            r3_bc <= DOT_W'(r2_bc[0]) + DOT_W'(r2_bc[1]) + DOT_W'(r2_bc[2]);
            r6_div.geo   <= r5_geo;
            r6_div.det   <= w_p[0] - w_p[1];
            r6_div.num_s <= w_p[2] - w_p[3];
            r6_div.num_t <= w_p[4] - w_p[5];
        end
    end

    spcp_wmul u_mul_abab (.i_clk, .i_ce(ce), .i_x(r3_ab), .i_y(r3_ab), .o_p(w_p[0]));
    spcp_wmul u_mul_aabb (.i_clk, .i_ce(ce), .i_x(r3_aa), .i_y(r3_bb), .o_p(w_p[1]));
    spcp_wmul u_mul_bbac (.i_clk, .i_ce(ce), .i_x(r3_bb), .i_y(r3_ac), .o_p(w_p[2]));
    spcp_wmul u_mul_abbc (.i_clk, .i_ce(ce), .i_x(r3_ab), .i_y(r3_bc), .o_p(w_p[3]));
    spcp_wmul u_mul_abac (.i_clk, .i_ce(ce), .i_x(r3_ab), .i_y(r3_ac), .o_p(w_p[4]));
    spcp_wmul u_mul_aabc (.i_clk, .i_ce(ce), .i_x(r3_aa), .i_y(r3_bc), .o_p(w_p[5]));

    spcp_div u_div (
        .i_clk,
        .i_rst_n,
        .i_ce   (ce),
        .i_vld  (r6_vld),
        .i_data (r6_div),
        .i_thr  (r_thr),
        .o_vld  (div_vld),
        .o_data (div_out)
    );

    spcp_gap u_gap (
        .i_clk,
        .i_rst_n,
        .i_ce   (ce),
        .i_vld  (div_vld),
        .i_data (div_out),
        .o_vld  (o_m_axis_tvalid),
        .o_data (o_m_axis_tdata)
    );

endmodule

// ===== sv/spcp_wmul.sv =====
// Signed 68 x 68 multiplier cut into four partial products, two register stages.
// Depends on spcp_pkg.
module spcp_wmul import spcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_ce,
    input  t_dot  i_x,
    input  t_dot  i_y,
    output t_wide o_p
);

    logic signed [HALF_W-1:0]   xh, yh;
    logic        [HALF_W-1:0]   xl, yl;
    logic        [2*HALF_W-1:0] r_ll;
    logic signed [2*HALF_W:0]   r_hl, r_lh;
    logic signed [2*HALF_W-1:0] r_hh;
    logic        [WIDE_W-1:0]   e_hh, e_hl, e_lh, e_ll;
    t_wide                      r_p;

    assign xh = i_x[DOT_W-1:HALF_W];
    assign yh = i_y[DOT_W-1:HALF_W];
    assign xl = i_x[HALF_W-1:0];
    assign yl = i_y[HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ll <= (2*HALF_W)'(xl * yl);
            r_hl <= (2*HALF_W+1)'(xh * $signed({1'b0, yl}));
            r_lh <= (2*HALF_W+1)'($signed({1'b0, xl}) * yh);
            r_hh <= (2*HALF_W)'(xh * yh);
        end
    end

    // align partial products, sign-extended; the high product fills the top half exactly
    assign e_hh = {r_hh, {(2*HALF_W){1'b0}}};
    assign e_hl = {{(WIDE_W-3*HALF_W-1){r_hl[2*HALF_W]}}, r_hl, {HALF_W{1'b0}}};
    assign e_lh = {{(WIDE_W-3*HALF_W-1){r_lh[2*HALF_W]}}, r_lh, {HALF_W{1'b0}}};
    assign e_ll = {{(WIDE_W-2*HALF_W){1'b0}}, r_ll};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p <= e_hh + e_hl + e_lh + e_ll;
        end
    end

    assign o_p = r_p;

endmodule

// ===== sv/spcp_div.sv =====
// Parameter divider: sign removal, parallel and clamp flags, one quotient bit per stage for s and t.
// Depends on spcp_pkg.
module spcp_div import spcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_vld,
    input  t_div_in          i_data,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_vld,
    output t_div_out         o_data
);

    logic              r0_vld;
    t_geom             r0_geo;
    logic [WIDE_W-1:0] r0_den, r0_ns, r0_nt;

    logic              r_vld [0:DIV_STEPS];
    t_geom             r_geo [0:DIV_STEPS];
    t_div_flags        r_fl  [0:DIV_STEPS];
    logic [WIDE_W-1:0] r_den [0:DIV_STEPS];
    logic [WIDE_W-1:0] r_rs  [0:DIV_STEPS];
    logic [WIDE_W-1:0] r_rt  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_qs [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_qt [0:DIV_STEPS];

    logic     r_out_vld;
    t_div_out r_out;
    t_div_flags n_fl;
    logic     neg;

    // take the sign of det out of all three
    assign neg = i_data.det[WIDE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_ce) begin
            r0_vld <= i_vld;
        end
        if (i_ce) begin
            r0_geo <= i_data.geo;
            r0_den <= neg ? -i_data.det   : i_data.det;
            r0_ns  <= neg ? -i_data.num_s : i_data.num_s;
            r0_nt  <= neg ? -i_data.num_t : i_data.num_t;
        end
    end

    always_comb begin
        n_fl.par   = r0_den < {{(WIDE_W-THR_W){1'b0}}, i_thr};
        n_fl.s_le0 = r0_ns[WIDE_W-1] | (r0_ns == '0);
        n_fl.s_ge1 = !r0_ns[WIDE_W-1] && (r0_ns >= r0_den);
        n_fl.t_le0 = r0_nt[WIDE_W-1] | (r0_nt == '0);
        n_fl.t_ge1 = !r0_nt[WIDE_W-1] && (r0_nt >= r0_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= r0_vld;
        end
        if (i_ce) begin
            r_geo[0] <= r0_geo;
            r_fl[0]  <= n_fl;
            r_den[0] <= r0_den;
            r_rs[0]  <= r0_ns;
            r_rt[0]  <= r0_nt;
            r_qs[0]  <= '0;
            r_qt[0]  <= '0;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        logic [WIDE_W-1:0] sh_s, sh_t;
        logic              ge_s, ge_t;

        assign sh_s = {r_rs[i][WIDE_W-2:0], 1'b0};
        assign sh_t = {r_rt[i][WIDE_W-2:0], 1'b0};
        assign ge_s = sh_s >= r_den[i];
        assign ge_t = sh_t >= r_den[i];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[i+1] <= r_vld[i];
            end
            if (i_ce) begin
                r_geo[i+1] <= r_geo[i];
                r_fl[i+1]  <= r_fl[i];
                r_den[i+1] <= r_den[i];
                r_rs[i+1]  <= ge_s ? sh_s - r_den[i] : sh_s;
                r_rt[i+1]  <= ge_t ? sh_t - r_den[i] : sh_t;
                r_qs[i+1]  <= {r_qs[i][DIV_STEPS-2:0], ge_s};
                r_qt[i+1]  <= {r_qt[i][DIV_STEPS-2:0], ge_t};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ce) begin
            r_out_vld <= r_vld[DIV_STEPS];
        end
        if (i_ce) begin
            r_out.geo <= r_geo[DIV_STEPS];
            if (r_fl[DIV_STEPS].par) begin
                r_out.s <= PARAM_HALF;
                r_out.t <= PARAM_HALF;
            end else begin
                r_out.s <= r_fl[DIV_STEPS].s_le0 ? '0 :
                           r_fl[DIV_STEPS].s_ge1 ? PARAM_ONE : {1'b0, r_qs[DIV_STEPS]};
                r_out.t <= r_fl[DIV_STEPS].t_le0 ? '0 :
                           r_fl[DIV_STEPS].t_ge1 ? PARAM_ONE : {1'b0, r_qt[DIV_STEPS]};
            end
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;

endmodule

// ===== sv/spcp_gap.sv =====
// Gap vector, its squared length and a one-bit-per-stage square root.
// Depends on spcp_pkg; its last stage is the output register of the block.
module spcp_gap import spcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_vld,
    input  t_div_out         i_data,
    output logic             o_vld,
    output logic [OUT_W-1:0] o_data
);

    logic                       r1_vld, r2_vld, r3_vld;
    logic signed [TB_W-1:0]     r1_tb [3];
    logic signed [TB_W-1:0]     r1_sa [3];
    t_diff                      r1_c  [3];
    t_param                     r1_s, r1_t, r2_s, r2_t, r3_s, r3_t;
    t_gap                       r2_g [3];
    t_gap                       r3_g [3];
    logic        [PROD_W-1:0]   r3_sq [3];
    t_gap                       n2_g [3];

    logic              r_vld  [0:ROOT_W];
    t_res              r_res  [0:ROOT_W];
    logic [SQ_W-1:0]   r_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_ce) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        if (i_ce) begin
            for (int j = 0; j < 3; j++) begin
                r1_tb[j] <= TB_W'($signed({1'b0, i_data.t}) * i_data.geo.b[j]);
                r1_sa[j] <= TB_W'($signed({1'b0, i_data.s}) * i_data.geo.a[j]);
                r1_c[j]  <= i_data.geo.c[j];
                r2_g[j]  <= n2_g[j];
                r3_g[j]  <= r2_g[j];
                r3_sq[j] <= PROD_W'(r2_g[j] * r2_g[j]);
            end
            r1_s <= i_data.s;
            r1_t <= i_data.t;
            r2_s <= r1_s;
            r2_t <= r1_t;
            r3_s <= r2_s;
            r3_t <= r2_t;
        end
    end

    // round once to the nearest unit, then saturate to the gap range
    always_comb begin
        logic signed [EXACT_W-1:0] exact;
        logic        [SHIFT_W-1:0] v;
        logic                      fits;
        for (int j = 0; j < 3; j++) begin
            exact = EXACT_W'(r1_tb[j]) - EXACT_W'(r1_sa[j])
                  - (EXACT_W'(r1_c[j]) <<< PARAM_FRAC) + ROUND_HALF;
            v     = exact[EXACT_W-1:PARAM_FRAC];
            fits  = (&v[SHIFT_W-1:GAP_W-1]) | ~(|v[SHIFT_W-1:GAP_W-1]);
            n2_g[j] = fits ? v[GAP_W-1:0] : (v[SHIFT_W-1] ? GAP_MIN : GAP_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= r3_vld;
        end
        if (i_ce) begin
            r_res[0].s <= r3_s;
            r_res[0].t <= r3_t;
            for (int j = 0; j < 3; j++) begin
                r_res[0].g[j] <= r3_g[j];
            end
            r_rem[0]  <= SQ_W'(r3_sq[0]) + SQ_W'(r3_sq[1]) + SQ_W'(r3_sq[2]);
            r_root[0] <= '0;
        end
    end

    // settle root bits from the top down; the remainder is sum - root^2
    for (genvar i = 0; i < ROOT_W; i++) begin : g_root
        localparam int K = ROOT_W - 1 - i;
        logic [SQ_W-1:0] trial;
        logic            ge;

        assign trial = (SQ_W'(r_root[i]) << (K + 1)) | (SQ_W'(1) << (2 * K));
        assign ge    = r_rem[i] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[i+1] <= r_vld[i];
            end
            if (i_ce) begin
                r_res[i+1]  <= r_res[i];
                r_rem[i+1]  <= ge ? r_rem[i] - trial : r_rem[i];
                r_root[i+1] <= r_root[i] | (ROOT_W'(ge) << K);
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_data = {{(OUT_W-OUT_BITS){1'b0}}, r_root[ROOT_W],
                     r_res[ROOT_W].g[2], r_res[ROOT_W].g[1], r_res[ROOT_W].g[0],
                     r_res[ROOT_W].t, r_res[ROOT_W].s};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for segment_pair_closest_points: streams segment pairs,
// predicts s, t, gap vector and gap length, and compares each result item.
// Depends on spcp_pkg and the segment_pair_closest_points RTL.
`timescale 1ns / 100ps

module tb_top import spcp_pkg::*; ();

    localparam int LATENCY = 62;

    typedef struct packed {
        logic [16:0] s;
        logic [16:0] t;
        logic [32:0] gx;
        logic [32:0] gy;
        logic [32:0] gz;
        logic [32:0] len;
    } t_contact;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [THR_W-1:0] cfg_data = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;

    logic [IN_W-1:0]  pair_queue[$];
    t_contact         contact_queue[$];
    logic [15:0]      threshold = 16'd1;
    int               errors = 0;
    int               burst_left = 0;
    int               gap_left = 0;
    int               stall_phase = 0;
    bit               sender_on = 1'b0;

    segment_pair_closest_points uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_cfg_data(cfg_data), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Signed quotient num/den clamped to [0,1], truncated to 16 fraction bits.
    function automatic logic [16:0] clamp_ratio(logic signed [299:0] num,
                                                logic signed [299:0] den);
        logic signed [299:0] q;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0) return 17'd0;
        if (num >= den) return 17'h10000;
        q = (num <<< 16) / den;
        return q[16:0];
    endfunction

    function automatic t_contact closest_points(logic [IN_W-1:0] pair);
        logic signed [63:0]  p1[3], q1[3], p2[3], q2[3], a[3], b[3], c[3], g[3];
        logic signed [299:0] aa, bb, ab, ac, bc, det, mag, sum, ex, v;
        logic [16:0]         s, t;
        logic [63:0]         root, cand;
        t_contact            r;
        aa = 0; bb = 0; ab = 0; ac = 0; bc = 0; sum = 0;
        for (int j = 0; j < 3; j++) begin
            p1[j] = $signed(pair[32*j +: 32]);
            q1[j] = $signed(pair[32*(3+j) +: 32]);
            p2[j] = $signed(pair[32*(6+j) +: 32]);
            q2[j] = $signed(pair[32*(9+j) +: 32]);
            a[j] = q1[j] - p1[j];
            b[j] = q2[j] - p2[j];
            c[j] = p1[j] - p2[j];
            aa += a[j] * a[j]; bb += b[j] * b[j]; ab += a[j] * b[j];
            ac += a[j] * c[j]; bc += b[j] * c[j];
        end
        det = ab * ab - aa * bb;
        mag = (det < 0) ? -det : det;
        if (mag < $signed({284'd0, threshold})) begin
            s = 17'h08000;
            t = 17'h08000;
        end else begin
            s = clamp_ratio(bb * ac - ab * bc, det);
            t = clamp_ratio(ab * ac - aa * bc, det);
        end
        for (int j = 0; j < 3; j++) begin
            ex = $signed({1'b0, t}) * b[j] - $signed({1'b0, s}) * a[j] - (c[j] <<< 16);
            v = (ex + 300'sd32768) >>> 16;
            if (v > 300'sd4294967295) v = 300'sd4294967295;
            if (v < -300'sd4294967296) v = -300'sd4294967296;
            g[j] = v[63:0];
            sum += v * v;
        end
        root = 0;
        for (int bit_n = 33; bit_n >= 0; bit_n--) begin
            cand = root | (64'd1 << bit_n);
            if ($signed({236'd0, cand}) * $signed({236'd0, cand}) <= sum) root = cand;
        end
        if (root > 64'h1_FFFF_FFFF) root = 64'h1_FFFF_FFFF;
        r.s = s; r.t = t;
        r.gx = g[0][32:0]; r.gy = g[1][32:0]; r.gz = g[2][32:0];
        r.len = root[32:0];
        return r;
    endfunction

    // Driver: bursts of items with random gaps in between.
    always @(posedge i_clk) begin
        if (s_tvalid && s_tready) contact_queue = {contact_queue, closest_points(s_tdata)};
        if (!s_tvalid || s_tready) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (sender_on && pair_queue.size() > 0) begin
                burst_left--;
                s_tdata <= pair_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: the receiver stalls on a slowly changing pattern of its own.
    always @(posedge i_clk) begin
        t_contact want, got;
        if (m_tvalid && m_tready) begin
            got = m_tdata[$bits(t_contact)-1:0];
            got = {m_tdata[16:0], m_tdata[33:17], m_tdata[66:34], m_tdata[99:67],
                   m_tdata[132:100], m_tdata[165:133]};
            if (contact_queue.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                want = contact_queue.pop_front();
                if (got.s !== want.s) begin
                    $error("param_first exp %h got %h", want.s, got.s); errors++;
                end
                if (got.t !== want.t) begin
                    $error("param_second exp %h got %h", want.t, got.t); errors++;
                end
                if (got.gx !== want.gx) begin
                    $error("gap_x exp %h got %h", want.gx, got.gx); errors++;
                end
                if (got.gy !== want.gy) begin
                    $error("gap_y exp %h got %h", want.gy, got.gy); errors++;
                end
                if (got.gz !== want.gz) begin
                    $error("gap_z exp %h got %h", want.gz, got.gz); errors++;
                end
                if (got.len !== want.len) begin
                    $error("gap_length exp %h got %h", want.len, got.len); errors++;
                end
            end
        end
        stall_phase = (stall_phase + 1) % 256;
        if (stall_phase < 64) m_tready <= 1'b1;
        else if (stall_phase < 128) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= ($urandom_range(0, 1) == 0);
    end

    function automatic logic [31:0] random_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2047)) - 1024) << 20;
            default: return 32'($signed($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    task automatic add_pair(logic [31:0] c0[12]);
        logic [IN_W-1:0] p;
        for (int k = 0; k < 12; k++) p[32*k +: 32] = c0[k];
        pair_queue = {pair_queue, p};
    endtask

    task automatic add_random(int count);
        logic [31:0] c0[12];
        int          mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 5);
            for (int k = 0; k < 12; k++) c0[k] = random_coord(mode > 3 ? 0 : mode);
            // Parallel or degenerate shapes now and then.
            if ($urandom_range(0, 7) == 0)
                for (int k = 0; k < 3; k++) c0[9+k] = c0[6+k] + (c0[3+k] - c0[k]);
            if ($urandom_range(0, 11) == 0)
                for (int k = 0; k < 3; k++) c0[3+k] = c0[k];
            add_pair(c0);
        end
    endtask

    task automatic drain_then_write(logic [15:0] value);
        while (pair_queue.size() > 0 || s_tvalid || contact_queue.size() > 0)
            @(posedge i_clk);
        sender_on = 1'b0;
        repeat (LATENCY + 4) @(posedge i_clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        threshold = value;
        @(posedge i_clk);
        sender_on = 1'b1;
    endtask

    initial begin
        logic [31:0] c0[12];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_on = 1'b1;
        // Directed: extremes, zero-length segments, parallel and crossing segments.
        for (int k = 0; k < 12; k++) c0[k] = 32'h0; add_pair(c0);
        for (int k = 0; k < 12; k++) c0[k] = 32'h7FFF_FFFF; add_pair(c0);
        for (int k = 0; k < 12; k++) c0[k] = 32'h8000_0000; add_pair(c0);
        for (int k = 0; k < 12; k++) c0[k] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        add_pair(c0);
        for (int k = 0; k < 12; k++) c0[k] = (k % 6 < 3) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        add_pair(c0);
        c0 = '{0, 0, 0, 32'h100000, 0, 0, 32'h80000, 32'hFFF80000, 32'h100000,
               32'h80000, 32'h80000, 32'h100000};
        add_pair(c0);
        c0 = '{0, 0, 0, 32'h100000, 0, 0, 0, 32'h100000, 0, 32'h100000, 32'h100000, 0};
        add_pair(c0);
        c0 = '{0, 0, 0, 32'h100000, 0, 0, 32'h300000, 0, 0, 32'h500000, 32'h1, 0};
        add_pair(c0);
        c0 = '{0, 0, 0, 32'h100000, 0, 0, 32'hFFD00000, 32'h10, 0, 32'hFFB00000, 0, 0};
        add_pair(c0);
        add_random(12);
        drain_then_write(16'd0);
        for (int k = 0; k < 12; k++) c0[k] = 32'h0; add_pair(c0);
        c0 = '{0, 0, 0, 32'h100000, 0, 0, 0, 32'h100000, 0, 32'h200000, 32'h100000, 0};
        add_pair(c0);
        add_random(200);
        drain_then_write(16'hFFFF);
        add_random(200);
        drain_then_write(16'($urandom));
        add_random(200);
        drain_then_write(16'd1);
        add_random(280);
        while (pair_queue.size() > 0 || s_tvalid || contact_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
